@@ rtl/mtl_pkg.sv @@
package mtl_pkg;

	// Integer bits of the ratio and of the result.
	localparam int INT_BITS = 8;

	// Threshold register layout: unsigned Q8.8.
	localparam int THR_WIDTH = 16;
	localparam int THR_FRAC = 8;
	localparam logic [THR_WIDTH-1:0] THR_RESET = 16'd256;

	// Decision taken at the front end, carried down the cell chain.
	typedef struct packed {
		logic do_div;
		logic base_zero;
		logic sat;
	} ctl_t;

endpackage

@@ rtl/mtl_front.sv @@
module mtl_front #(
	parameter int SLOPE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SLOPE_WIDTH-1:0] slope_old,
	input  logic signed [SLOPE_WIDTH-1:0] slope_new,
	input  logic [mtl_pkg::THR_WIDTH-1:0] thr,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [SLOPE_WIDTH-1:0]        mold,
	output logic [SLOPE_WIDTH-1:0]        mnew,
	output mtl_pkg::ctl_t                 ctl
);

	localparam int PW = SLOPE_WIDTH + mtl_pkg::THR_WIDTH;
	localparam int SW = SLOPE_WIDTH + mtl_pkg::INT_BITS;

	logic                   valid_s1;
	logic [SLOPE_WIDTH-1:0] mold_s1;
	logic [SLOPE_WIDTH-1:0] mnew_s1;
	logic [PW-1:0]          prod_s1;
	logic                   same_s1;
	logic                   valid_s2;
	logic [SLOPE_WIDTH-1:0] mold_s2;
	logic [SLOPE_WIDTH-1:0] mnew_s2;
	mtl_pkg::ctl_t          ctl_s2;

	logic                   ready_s1;
	logic                   ready_s2;
	logic [SLOPE_WIDTH-1:0] so_u;
	logic [SLOPE_WIDTH-1:0] sn_u;
	logic [SLOPE_WIDTH-1:0] mold_d;
	logic [SLOPE_WIDTH-1:0] mnew_d;
	logic [SW-1:0]          mold_sh;
	logic                   nz;
	logic                   lim;
	logic                   sat_c;
	mtl_pkg::ctl_t          ctl_d;

	// Each stage moves when the one after it is empty or moving.
	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// Exact magnitudes; the most negative value maps to 2^(width-1).
	assign so_u   = $unsigned(slope_old);
	assign sn_u   = $unsigned(slope_new);
	assign mold_d = so_u[SLOPE_WIDTH-1] ? (~so_u + 1'b1) : so_u;
	assign mnew_d = sn_u[SLOPE_WIDTH-1] ? (~sn_u + 1'b1) : sn_u;

	// Stage one: magnitudes, sign match and threshold product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			mold_s1 <= mold_d;
			mnew_s1 <= mnew_d;
			prod_s1 <= PW'(thr) * PW'(mnew_d);
			same_s1 <= so_u[SLOPE_WIDTH-1] == sn_u[SLOPE_WIDTH-1];
		end
	end

	// Threshold and saturation compares pick how the base value is formed.
	assign mold_sh = {mold_s1, mtl_pkg::THR_FRAC'(0)};
	assign nz      = (|mold_s1) && (|mnew_s1) && same_s1;
	assign lim     = prod_s1 < PW'(mold_sh);
	assign sat_c   = SW'(mnew_s1) >= {mold_s1, mtl_pkg::INT_BITS'(0)};

	always_comb begin
		ctl_d.do_div    = nz && lim && !sat_c;
		ctl_d.sat       = nz && lim && sat_c;
		ctl_d.base_zero = !nz && (|mold_s1);
	end

	// Stage two: decision register feeding the divider chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			mold_s2 <= mold_s1;
			mnew_s2 <= mnew_s1;
			ctl_s2  <= ctl_d;
		end
	end

	assign out_valid = valid_s2;
	assign mold      = mold_s2;
	assign mnew      = mnew_s2;
	assign ctl       = ctl_s2;

endmodule

@@ rtl/mtl_div_cell.sv @@
module mtl_div_cell #(
	parameter int SLOPE_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [SLOPE_WIDTH-1:0]                  in_rem,
	input  logic [SLOPE_WIDTH-1:0]                  in_den,
	input  logic [mtl_pkg::INT_BITS+FRAC_BITS-1:0]  in_rest,
	input  logic [mtl_pkg::INT_BITS+FRAC_BITS-1:0]  in_quo,
	input  mtl_pkg::ctl_t                           in_ctl,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [SLOPE_WIDTH-1:0]                  out_rem,
	output logic [SLOPE_WIDTH-1:0]                  out_den,
	output logic [mtl_pkg::INT_BITS+FRAC_BITS-1:0]  out_rest,
	output logic [mtl_pkg::INT_BITS+FRAC_BITS-1:0]  out_quo,
	output mtl_pkg::ctl_t                           out_ctl
);

	localparam int QW = mtl_pkg::INT_BITS + FRAC_BITS;

	logic                   valid_q;
	logic [SLOPE_WIDTH-1:0] rem_q;
	logic [SLOPE_WIDTH-1:0] den_q;
	logic [QW-1:0]          rest_q;
	logic [QW-1:0]          quo_q;
	mtl_pkg::ctl_t          ctl_q;

	logic [SLOPE_WIDTH:0]   trial;
	logic [SLOPE_WIDTH:0]   diff;
	logic                   ge;

	assign in_ready = !valid_q || out_ready;

	// One restoring step: bring down the next dividend bit and subtract if it fits.
	assign trial = {in_rem, in_rest[QW-1]};
	assign diff  = trial - {1'b0, in_den};
	assign ge    = trial >= {1'b0, in_den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rem_q  <= ge ? diff[SLOPE_WIDTH-1:0] : trial[SLOPE_WIDTH-1:0];
			den_q  <= in_den;
			rest_q <= {in_rest[QW-2:0], 1'b0};
			quo_q  <= {in_quo[QW-2:0], ge};
			ctl_q  <= in_ctl;
		end
	end

	assign out_valid = valid_q;
	assign out_rem   = rem_q;
	assign out_den   = den_q;
	assign out_rest  = rest_q;
	assign out_quo   = quo_q;
	assign out_ctl   = ctl_q;

endmodule

@@ rtl/mtl_sqrt_cell.sv @@
module mtl_sqrt_cell #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        in_valid,
	output logic                                        in_ready,
	input  logic [mtl_pkg::INT_BITS/2+FRAC_BITS:0]      in_rem,
	input  logic [mtl_pkg::INT_BITS/2+FRAC_BITS-1:0]    in_root,
	input  logic [mtl_pkg::INT_BITS+2*FRAC_BITS-1:0]    in_rad,
	input  mtl_pkg::ctl_t                               in_ctl,
	output logic                                        out_valid,
	input  logic                                        out_ready,
	output logic [mtl_pkg::INT_BITS/2+FRAC_BITS:0]      out_rem,
	output logic [mtl_pkg::INT_BITS/2+FRAC_BITS-1:0]    out_root,
	output logic [mtl_pkg::INT_BITS+2*FRAC_BITS-1:0]    out_rad,
	output mtl_pkg::ctl_t                               out_ctl
);

	localparam int RW = mtl_pkg::INT_BITS / 2 + FRAC_BITS;
	localparam int XW = 2 * RW;

	logic             valid_q;
	logic [RW:0]      rem_q;
	logic [RW-1:0]    root_q;
	logic [XW-1:0]    rad_q;
	mtl_pkg::ctl_t    ctl_q;

	logic [RW+2:0]    cur;
	logic [RW+2:0]    trial;
	logic [RW+2:0]    diff;
	logic             ge;

	assign in_ready = !valid_q || out_ready;

	// One root digit: bring down two radicand bits, try 4*root+1.
	assign cur   = {in_rem, in_rad[XW-1:XW-2]};
	assign trial = {1'b0, in_root, 2'b01};
	assign diff  = cur - trial;
	assign ge    = cur >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rem_q  <= ge ? diff[RW:0] : cur[RW:0];
			root_q <= {in_root[RW-2:0], ge};
			rad_q  <= {in_rad[XW-3:0], 2'b00};
			ctl_q  <= in_ctl;
		end
	end

	assign out_valid = valid_q;
	assign out_rem   = rem_q;
	assign out_root  = root_q;
	assign out_rad   = rad_q;
	assign out_ctl   = ctl_q;

endmodule

@@ rtl/minmod_time_limiter_top.sv @@
// Minmod time limiter.
// Input channel (in_valid/in_ready) takes a pair of signed slopes, slope_old and
// slope_new, with FRAC_BITS fraction bits. Output channel (out_valid/out_ready)
// returns limiter_value, the square root of the limited ratio in unsigned
// Q8.FRAC_BITS, and ratio_saturated. The configuration channel (cfg_valid/cfg_ready/
// cfg_data) writes the Q8.8 slope ratio threshold; it is always ready and should
// only be written while no transfer is in flight.
// The chain is made of two front stages, one divider cell per quotient bit and
// one square root cell per root bit. One item is accepted per cycle while the
// chain has room.
// Every cell holds its own valid bit and moves whenever the next cell is empty or
// moving, so a stalled receiver fills the empty cells first and the input keeps
// taking transfers until the chain is full.
// Reset empties the chain and sets the threshold to 1.0.
module minmod_time_limiter_top #(
	parameter int SLOPE_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [SLOPE_WIDTH-1:0]          slope_old,
	input  logic signed [SLOPE_WIDTH-1:0]          slope_new,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [mtl_pkg::INT_BITS+FRAC_BITS-1:0] limiter_value,
	output logic                                   ratio_saturated,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [mtl_pkg::THR_WIDTH-1:0]          cfg_data
);

	localparam int QW = mtl_pkg::INT_BITS + FRAC_BITS;
	localparam int RW = mtl_pkg::INT_BITS / 2 + FRAC_BITS;
	localparam int XW = 2 * RW;
	localparam int ND = QW;
	localparam int NS = RW;
	localparam logic [QW-1:0] ONE_VAL = QW'(1) << FRAC_BITS;
	localparam logic [QW-1:0] OUT_MAX = {QW{1'b1}};
	localparam logic [RW-1:0] ROOT_MAX = {RW{1'b1}};

	logic [mtl_pkg::THR_WIDTH-1:0] thr_q;

	logic                   f_valid;
	logic [SLOPE_WIDTH-1:0] f_mold;
	logic [SLOPE_WIDTH-1:0] f_mnew;
	mtl_pkg::ctl_t          f_ctl;

	logic                   div_valid [ND+1];
	logic                   div_ready [ND+1];
	logic [SLOPE_WIDTH-1:0] div_rem   [ND+1];
	logic [SLOPE_WIDTH-1:0] div_den   [ND+1];
	logic [QW-1:0]          div_rest  [ND+1];
	logic [QW-1:0]          div_quo   [ND+1];
	mtl_pkg::ctl_t          div_ctl   [ND+1];

	logic                   sq_valid [NS+1];
	logic                   sq_ready [NS+1];
	logic [RW:0]            sq_rem   [NS+1];
	logic [RW-1:0]          sq_root  [NS+1];
	logic [XW-1:0]          sq_rad   [NS+1];
	mtl_pkg::ctl_t          sq_ctl   [NS+1];

	logic [QW-1:0]          base;

	// Threshold register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= mtl_pkg::THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	// Front end: magnitudes, threshold and saturation decisions.
	mtl_front #(
		.SLOPE_WIDTH(SLOPE_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.slope_old(slope_old),
		.slope_new(slope_new),
		.thr      (thr_q),
		.out_valid(f_valid),
		.out_ready(div_ready[0]),
		.mold     (f_mold),
		.mnew     (f_mnew),
		.ctl      (f_ctl)
	);

	// The dividend is |new| with FRAC_BITS zeros appended; its top part is already
	// below the divisor, so the chain yields 8 + FRAC_BITS quotient bits.
	assign div_valid[0] = f_valid;
	assign div_rem[0]   = SLOPE_WIDTH'(f_mnew[SLOPE_WIDTH-1:mtl_pkg::INT_BITS]);
	assign div_den[0]   = f_mold;
	assign div_rest[0]  = {f_mnew[mtl_pkg::INT_BITS-1:0], FRAC_BITS'(0)};
	assign div_quo[0]   = '0;
	assign div_ctl[0]   = f_ctl;

	for (genvar i = 0; i < ND; i++) begin : g_div
		mtl_div_cell #(
			.SLOPE_WIDTH(SLOPE_WIDTH),
			.FRAC_BITS  (FRAC_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (div_valid[i]),
			.in_ready (div_ready[i]),
			.in_rem   (div_rem[i]),
			.in_den   (div_den[i]),
			.in_rest  (div_rest[i]),
			.in_quo   (div_quo[i]),
			.in_ctl   (div_ctl[i]),
			.out_valid(div_valid[i+1]),
			.out_ready(div_ready[i+1]),
			.out_rem  (div_rem[i+1]),
			.out_den  (div_den[i+1]),
			.out_rest (div_rest[i+1]),
			.out_quo  (div_quo[i+1]),
			.out_ctl  (div_ctl[i+1])
		);
	end

	// Base value: quotient, zero, the clamp value or 1.0.
	always_comb begin
		if (div_ctl[ND].do_div) begin
			base = div_quo[ND];
		end else if (div_ctl[ND].base_zero) begin
			base = '0;
		end else if (div_ctl[ND].sat) begin
			base = OUT_MAX;
		end else begin
			base = ONE_VAL;
		end
	end

	assign sq_valid[0]  = div_valid[ND];
	assign div_ready[ND] = sq_ready[0];
	assign sq_rem[0]    = '0;
	assign sq_root[0]   = '0;
	assign sq_rad[0]    = {base, FRAC_BITS'(0)};
	assign sq_ctl[0]    = div_ctl[ND];

	for (genvar j = 0; j < NS; j++) begin : g_sqrt
		mtl_sqrt_cell #(
			.FRAC_BITS(FRAC_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (sq_valid[j]),
			.in_ready (sq_ready[j]),
			.in_rem   (sq_rem[j]),
			.in_root  (sq_root[j]),
			.in_rad   (sq_rad[j]),
			.in_ctl   (sq_ctl[j]),
			.out_valid(sq_valid[j+1]),
			.out_ready(sq_ready[j+1]),
			.out_rem  (sq_rem[j+1]),
			.out_root (sq_root[j+1]),
			.out_rad  (sq_rad[j+1]),
			.out_ctl  (sq_ctl[j+1])
		);
	end

	// The last root cell is the output register.
	assign sq_ready[NS]    = out_ready;
	assign out_valid       = sq_valid[NS];
	assign limiter_value   = QW'(sq_root[NS]);
	assign ratio_saturated = sq_ctl[NS].sat;

	// A clamped ratio has the all-ones root.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ratio_saturated |-> limiter_value == QW'(ROOT_MAX))
		else $error("saturated result without all-ones root");

	// The front end selects at most one way of forming the base value.
	assert property (@(posedge clk) disable iff (!arst_n)
		f_valid |-> $onehot0(f_ctl))
		else $error("conflicting base value decision");

	// With the receiver taking transfers, every cell moves and input is open.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input blocked while the receiver is ready");

endmodule
